### rtl/hjl_pkg.sv
// Package for the hash join lookup: sizes, item types, op codes and the key hash.
package hjl_pkg;

  // Table size and derived widths
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W         = 32;
  localparam int ENT_W         = KEY_W + 1;

  // Op codes of an input beat
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_PROBE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Status codes of a result beat
  localparam logic ST_PAIR = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // Input beat
  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
  } in_t;

  // Result beat
  typedef struct packed {
    logic signed [KEY_W-1:0] left_value;
    logic signed [KEY_W-1:0] right_value;
    logic                    status;
  } out_t;

  // Lookup outcome handed from the sequencer to the output stage
  typedef struct packed {
    logic             valid;
    logic             full;
    logic             hit;
    logic [KEY_W-1:0] key;
  } res_t;

  // Fold the key into a home slot below TABLE_ENTRIES
  function automatic logic [IDX_W-1:0] hash_key(input logic [KEY_W-1:0] k);
    logic [15:0]    t;
    logic [IDX_W:0] h;
    t = k[31:16] ^ k[15:0];
    h = '0;
    for (int i = 0; i < 16; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ t[i];
    end
    h[IDX_W] = 1'b0;
    if (h >= (IDX_W+1)'(TABLE_ENTRIES)) begin
      h = h - (IDX_W+1)'(TABLE_ENTRIES);
    end
    return h[IDX_W-1:0];
  endfunction

endpackage

### rtl/hjl_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module hjl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/hjl_seq.sv
// Sequencer: clearing sweep and linear-probe search over the key table.
module hjl_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hjl_pkg::in_t                  in_data,
  output hjl_pkg::res_t                 res,
  input  logic                          res_ready,
  output logic                          ram_we,
  output logic [hjl_pkg::IDX_W-1:0]     ram_waddr,
  output logic [hjl_pkg::ENT_W-1:0]     ram_wdata,
  output logic                          ram_re,
  output logic [hjl_pkg::IDX_W-1:0]     ram_raddr,
  input  logic [hjl_pkg::ENT_W-1:0]     ram_rdata
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_RES
  } state_t;

  localparam logic [hjl_pkg::IDX_W-1:0] LAST_IDX =
    hjl_pkg::IDX_W'(hjl_pkg::TABLE_ENTRIES - 1);
  localparam logic [hjl_pkg::CNT_W-1:0] FULL_CNT =
    hjl_pkg::CNT_W'(hjl_pkg::TABLE_ENTRIES);

  state_t                        state_r,  state_nxt;
  logic [hjl_pkg::IDX_W-1:0]     clr_r,    clr_nxt;
  logic [hjl_pkg::IDX_W-1:0]     slot_r,   slot_nxt;
  logic [hjl_pkg::IDX_W-1:0]     probe_r,  probe_nxt;
  logic [hjl_pkg::CNT_W-1:0]     cnt_r,    cnt_nxt;
  logic [hjl_pkg::KEY_W-1:0]     key_r,    key_nxt;
  hjl_pkg::op_t                  op_r,     op_nxt;
  logic                          full_r,   full_nxt;
  logic                          hit_r,    hit_nxt;
  logic                          accept;
  logic                          ent_valid;
  logic                          ent_match;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign ent_valid = ram_rdata[hjl_pkg::ENT_W-1];
  assign ent_match = ent_valid && (ram_rdata[hjl_pkg::KEY_W-1:0] == key_r);

  // Memory port drive
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    if (state_r == S_CLR) begin
      ram_we = 1'b1;
    end else if (state_r == S_CHECK && op_r == hjl_pkg::OP_INSERT && !ent_valid
                 && cnt_r != FULL_CNT) begin
      ram_we    = 1'b1;
      ram_waddr = slot_r;
      ram_wdata = {1'b1, key_r};
    end
  end

  assign ram_re    = (state_r == S_LOOK);
  assign ram_raddr = slot_r;

  // Result to the output stage
  always_comb begin
    res.valid = (state_r == S_RES);
    res.full  = full_r;
    res.hit   = hit_r;
    res.key   = key_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    slot_nxt  = slot_r;
    probe_nxt = probe_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    op_nxt    = op_r;
    full_nxt  = full_r;
    hit_nxt   = hit_r;
    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          clr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          key_nxt   = in_data.key;
          op_nxt    = in_data.op;
          slot_nxt  = hjl_pkg::hash_key(in_data.key);
          probe_nxt = '0;
          full_nxt  = 1'b0;
          hit_nxt   = 1'b0;
          unique case (in_data.op) inside
            hjl_pkg::OP_CLEAR: begin
              clr_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_CLR;
            end
            hjl_pkg::OP_INSERT, hjl_pkg::OP_PROBE: state_nxt = S_LOOK;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOOK: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (ent_match) begin
          hit_nxt   = 1'b1;
          state_nxt = (op_r == hjl_pkg::OP_INSERT) ? S_IDLE : S_RES;
        end else if (!ent_valid) begin
          if (op_r == hjl_pkg::OP_INSERT) begin
            if (cnt_r == FULL_CNT) begin
              full_nxt  = 1'b1;
              state_nxt = S_RES;
            end else begin
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_RES;
          end
        end else if (probe_r == LAST_IDX) begin
          // every slot visited without a match or a hole
          full_nxt  = (op_r == hjl_pkg::OP_INSERT);
          state_nxt = S_RES;
        end else begin
          slot_nxt  = (slot_r == LAST_IDX) ? '0 : slot_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_RES: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Payload of the item in flight
  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    probe_r <= probe_nxt;
    key_r   <= key_nxt;
    op_r    <= op_nxt;
    full_r  <= full_nxt;
    hit_r   <= hit_nxt;
  end

endmodule

### rtl/hash_join_lookup.sv
// Top level of the hash join lookup: key table, sequencer, side register and result stage.
//
// Use: a build phase sends insert beats, a probe phase sends probe beats; a clear
// beat empties the table. The input channel (in_valid, in_stall, in_data) takes one
// beat at a time; in_stall is high while an item is being worked on. The result
// channel (out_valid, out_stall, out_data) gives one beat per probe and one per
// insert of a new key into a full table (status 1, both values zero). cfg_we and
// cfg_wdata write join_side; write it only while the block is idle.
// Search: an item visits the slots of the linearly probed table in turn, with a read
// state and a check state per slot through the table's single registered read port;
// any result is then placed in the result register, and the next beat may be accepted
// once the sequencer is idle again. A clear beat holds in_stall high while the table
// is swept clear.
// Reset: rst_n is synchronous, active low. After reset the table is swept clear, slot
// by slot, with in_stall high; join_side resets to left join.
// Stall: the result register holds its beat while out_stall is high; a new item may
// still be accepted, and its result waits in the sequencer until the register frees.
module hash_join_lookup (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hjl_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hjl_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);

  logic                          join_side_r;
  logic                          out_valid_r;
  hjl_pkg::out_t                 out_data_r, out_data_nxt;
  hjl_pkg::res_t                 res;
  logic                          res_ready;
  logic                          ram_we;
  logic [hjl_pkg::IDX_W-1:0]     ram_waddr;
  logic [hjl_pkg::ENT_W-1:0]     ram_wdata;
  logic                          ram_re;
  logic [hjl_pkg::IDX_W-1:0]     ram_raddr;
  logic [hjl_pkg::ENT_W-1:0]     ram_rdata;
  logic [hjl_pkg::KEY_W-1:0]     other;

  hjl_ram #(
    .DEPTH (hjl_pkg::TABLE_ENTRIES),
    .WIDTH (hjl_pkg::ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hjl_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res       (res),
    .res_ready (res_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Result register is free when empty or being taken
  assign res_ready = !out_valid_r || !out_stall;

  // Place probe key and match on their sides, or zero both values for a full report
  always_comb begin
    other = res.hit ? res.key : '1;
    if (res.full) begin
      out_data_nxt.left_value  = '0;
      out_data_nxt.right_value = '0;
      out_data_nxt.status      = hjl_pkg::ST_FULL;
    end else begin
      out_data_nxt.left_value  = join_side_r ? other : res.key;
      out_data_nxt.right_value = join_side_r ? res.key : other;
      out_data_nxt.status      = hjl_pkg::ST_PAIR;
    end
  end

  // Hold the side register and the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      join_side_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        join_side_r <= cfg_wdata;
      end
      if (res_ready) begin
        out_valid_r <= res.valid;
      end
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/hjl_chk.sv
// Port checker for the hash join lookup, bound to the top level.
module hjl_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input hjl_pkg::in_t   in_data,
  input logic           out_valid,
  input logic           out_stall,
  input hjl_pkg::out_t  out_data
);

  // A stalled result beat stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed under stall");

  // A full-table report carries zero values
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == hjl_pkg::ST_FULL |->
      out_data.left_value == 0 && out_data.right_value == 0)
    else $error("full report with non-zero values");

  // A pair is either a match or holds -1 on one side
  a_pair_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == hjl_pkg::ST_PAIR |->
      out_data.left_value == out_data.right_value ||
      out_data.left_value == -1 || out_data.right_value == -1)
    else $error("pair neither matched nor marked missing");

  // A working op keeps the input busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
      (in_data.op == hjl_pkg::OP_CLEAR || in_data.op == hjl_pkg::OP_INSERT ||
       in_data.op == hjl_pkg::OP_PROBE) |=> in_stall)
    else $error("input taken again while an item is in flight");

endmodule

bind hash_join_lookup hjl_chk u_hjl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
